@@ rtl/sgeos_pkg.sv @@
// ----------------------------------------------------------------------------
// sgeos_pkg
// Types, register map and step functions of the stiffened-gas property pipeline.
// ----------------------------------------------------------------------------
package sgeos_pkg;

	localparam int DIV_A_STEPS = 80;
	localparam int DIV_B_STEPS = 101;
	localparam int SQRT_STEPS  = 40;

	localparam logic [1:0] REG_HEAT_RATIO    = 2'd0;
	localparam logic [1:0] REG_HEAT_CAPACITY = 2'd1;
	localparam logic [1:0] REG_STIFFNESS     = 2'd2;
	localparam logic [1:0] REG_ACTIVE_DIMS   = 2'd3;

	localparam logic [27:0] HEAT_RATIO_RST    = 28'd32413581;
	localparam logic [39:0] HEAT_CAPACITY_RST = 40'd530519163;
	localparam logic [47:0] STIFFNESS_RST     = 48'd298112000000;
	localparam logic [1:0]  ACTIVE_DIMS_RST   = 2'd3;

	typedef struct packed {
		logic [39:0]       rho;
		logic              eneg;
		logic [4:0][120:0] rq;
	} diva_t;

	typedef struct packed {
		logic [39:0]  rho;
		logic         sinv;
		logic         tneg;
		logic         sat;
		logic [55:0]  e;
		logic [55:0]  p;
		logic [141:0] rs;
		logic [149:0] rt;
	} divb_t;

	typedef struct packed {
		logic        asat;
		logic        sinv;
		logic        sat;
		logic [55:0] e;
		logic [55:0] p;
		logic [39:0] t;
		logic [43:0] rem;
		logic [39:0] root;
		logic [79:0] rad;
	} sqrt_t;

	function automatic logic [47:0] mag48(input logic [47:0] v);
		return v[47] ? (~v + 48'd1) : v;
	endfunction

	function automatic logic [120:0] div_step_a(input logic [120:0] rq, input logic [39:0] d);
		logic [120:0] sh;
		logic [40:0]  top;
		sh  = {rq[119:0], 1'b0};
		top = sh[120:80];
		if (top >= {1'b0, d}) begin
			sh[120:80] = top - {1'b0, d};
			sh[0]      = 1'b1;
		end
		return sh;
	endfunction

	function automatic logic [141:0] div_step_s(input logic [141:0] rq, input logic [39:0] d);
		logic [141:0] sh;
		logic [40:0]  top;
		sh  = {rq[140:0], 1'b0};
		top = sh[141:101];
		if (top >= {1'b0, d}) begin
			sh[141:101] = top - {1'b0, d};
			sh[0]       = 1'b1;
		end
		return sh;
	endfunction

	function automatic logic [149:0] div_step_t(input logic [149:0] rq, input logic [47:0] d);
		logic [149:0] sh;
		logic [48:0]  top;
		sh  = {rq[148:0], 1'b0};
		top = sh[149:101];
		if (top >= {1'b0, d}) begin
			sh[149:101] = top - {1'b0, d};
			sh[0]       = 1'b1;
		end
		return sh;
	endfunction

	function automatic sqrt_t sqrt_step(input sqrt_t x);
		sqrt_t       y;
		logic [43:0] r2;
		logic [43:0] tr;
		y   = x;
		r2  = {x.rem[41:0], x.rad[79:78]};
		tr  = {2'b00, x.root, 2'b01};
		y.rad = {x.rad[77:0], 2'b00};
		if (r2 >= tr) begin
			y.rem  = r2 - tr;
			y.root = {x.root[38:0], 1'b1};
		end else begin
			y.rem  = r2;
			y.root = {x.root[38:0], 1'b0};
		end
		return y;
	endfunction

endpackage

@@ rtl/stiffened_gas_conserved_to_properties_top.sv @@
// ----------------------------------------------------------------------------
// stiffened_gas_conserved_to_properties_top
// Stiffened-gas equation of state: conserved cell state to e, p, a and T.
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// cfg      in         psel/penable/pwrite  paddr, pwdata (prdata back)
// in       in         in_valid/in_ready    density, energy_density, momentum_x/y/z
// out      out        out_valid/out_ready  internal_energy, pressure, sound_speed,
//                                          temperature, sound_invalid, saturated
// One word per cycle in, one per cycle out.
// The pipeline runs through the 80-step velocity/energy divider, the 101-step
// sound/temperature divider and the 40-step square root, one bit per stage.
// All stages advance together; the pipeline holds whenever the output word waits.
// Reset clears valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module stiffened_gas_conserved_to_properties_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [39:0]        density,
	input  logic signed [55:0] energy_density,
	input  logic signed [47:0] momentum_x,
	input  logic signed [47:0] momentum_y,
	input  logic signed [47:0] momentum_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [55:0] internal_energy,
	output logic signed [55:0] pressure,
	output logic [39:0]        sound_speed,
	output logic signed [39:0] temperature,
	output logic               sound_invalid,
	output logic               saturated
);

	localparam int NA = sgeos_pkg::DIV_A_STEPS;
	localparam int NB = sgeos_pkg::DIV_B_STEPS;
	localparam int NS = sgeos_pkg::SQRT_STEPS;

	logic [27:0] heat_ratio_q;
	logic [39:0] heat_capacity_q;
	logic [47:0] stiffness_pressure_q;
	logic [1:0]  active_dims_q;
	logic [51:0] gp_hi_q;
	logic [51:0] gp_lo_q;
	logic [75:0] gp0_q;
	logic signed [28:0] gm;
	logic [47:0] cp_div;
	logic        adv;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heat_ratio_q         <= sgeos_pkg::HEAT_RATIO_RST;
			heat_capacity_q      <= sgeos_pkg::HEAT_CAPACITY_RST;
			stiffness_pressure_q <= sgeos_pkg::STIFFNESS_RST;
			active_dims_q        <= sgeos_pkg::ACTIVE_DIMS_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[4:3])
				sgeos_pkg::REG_HEAT_RATIO:    heat_ratio_q         <= pwdata[27:0];
				sgeos_pkg::REG_HEAT_CAPACITY: heat_capacity_q      <= pwdata[39:0];
				sgeos_pkg::REG_STIFFNESS:     stiffness_pressure_q <= pwdata[47:0];
				sgeos_pkg::REG_ACTIVE_DIMS:   active_dims_q        <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:3])
			sgeos_pkg::REG_HEAT_RATIO:    prdata = {36'd0, heat_ratio_q};
			sgeos_pkg::REG_HEAT_CAPACITY: prdata = {24'd0, heat_capacity_q};
			sgeos_pkg::REG_STIFFNESS:     prdata = {16'd0, stiffness_pressure_q};
			sgeos_pkg::REG_ACTIVE_DIMS:   prdata = {62'd0, active_dims_q};
			default:                      prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	always_ff @(posedge clk) begin
		gp_hi_q <= heat_ratio_q * stiffness_pressure_q[47:24];
		gp_lo_q <= heat_ratio_q * stiffness_pressure_q[23:0];
		gp0_q   <= {gp_hi_q, 24'd0} + {24'd0, gp_lo_q};
	end

	assign gm     = $signed({1'b0, heat_ratio_q}) - 29'sd16777216;
	assign cp_div = {(heat_capacity_q == '0) ? 40'd1 : heat_capacity_q, 8'd0};

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// ---------------- velocity, energy quotient, p0/rho ----------------
	logic [39:0]  rho_in;
	logic [47:0]  mx, my, mz;
	logic [55:0]  emag;
	logic [4:0][120:0] rq_in;

	always_comb begin
		rho_in = (density == '0) ? 40'd1 : density;
		mx = (active_dims_q > 2'd0) ? sgeos_pkg::mag48(momentum_x) : '0;
		my = (active_dims_q > 2'd1) ? sgeos_pkg::mag48(momentum_y) : '0;
		mz = (active_dims_q > 2'd2) ? sgeos_pkg::mag48(momentum_z) : '0;
		emag = energy_density[55] ? (~energy_density + 56'd1) : energy_density;
		rq_in[0] = {57'd0, mx, 16'd0};
		rq_in[1] = {57'd0, my, 16'd0};
		rq_in[2] = {57'd0, mz, 16'd0};
		rq_in[3] = {41'd0, emag, 24'd0};
		rq_in[4] = {49'd0, stiffness_pressure_q, 24'd0};
	end

	sgeos_pkg::diva_t da_s [NA];
	logic [NA-1:0]    da_vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			da_vld_s <= '0;
		end else if (adv) begin
			da_vld_s <= {da_vld_s[NA-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			da_s[0].rho  <= rho_in;
			da_s[0].eneg <= energy_density[55];
			for (int j = 0; j < 5; j++) begin
				da_s[0].rq[j] <= sgeos_pkg::div_step_a(rq_in[j], rho_in);
			end
			for (int k = 1; k < NA; k++) begin
				da_s[k].rho  <= da_s[k-1].rho;
				da_s[k].eneg <= da_s[k-1].eneg;
				for (int j = 0; j < 5; j++) begin
					da_s[k].rq[j] <= sgeos_pkg::div_step_a(da_s[k-1].rq[j], da_s[k-1].rho);
				end
			end
		end
	end

	// ---------------- kinetic energy, internal energy, pressure ----------------
	logic [2:0][49:0] u_c;
	logic [80:0]      qs_c;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			u_c[j] = (|da_s[NA-1].rq[j][79:50]) ? {1'b1, 49'd0} : da_s[NA-1].rq[j][49:0];
		end
		qs_c = da_s[NA-1].eneg ? (~{1'b0, da_s[NA-1].rq[3][79:0]} + 81'd1)
			: {1'b0, da_s[NA-1].rq[3][79:0]};
	end

	logic v_s81, v_s82, v_s83, v_s84, v_s85, v_s86, v_s87, v_s88, v_s89, v_s90, v_s91;
	logic [2:0][49:0]   hh_s81, hl_s81, ll_s81;
	logic [80:0]        qs_s81, qs_s82, qs_s83;
	logic [71:0]        pr_s81, pr_s82, pr_s83, pr_s84;
	logic [39:0]        rho_s81, rho_s82, rho_s83, rho_s84, rho_s85, rho_s86, rho_s87;
	logic [39:0]        rho_s88, rho_s89, rho_s90, rho_s91;
	logic signed [49:0] gph_s81, gpl_s81;
	logic [2:0][99:0]   sq_s82;
	logic [68:0]        grho_s82, grho_s83, grho_s84;
	logic [84:0]        ke_s83;
	logic [55:0]        e_s84, e_s85, e_s86, e_s87, e_s88, e_s89, e_s90, e_s91;
	logic               esat_s84, esat_s85, esat_s86, esat_s87, esat_s88, esat_s89;
	logic signed [57:0] pt_s85 [3][2];
	logic [73:0]        dd_s85;
	logic [127:0]       ta_s86, tb_s86, t1_s87, v_acc_s88;
	logic               ddneg_s86, ddneg_s87, ddneg_s88, ddneg_s89, ddneg_s90, ddneg_s91;
	logic [72:0]        ddmag_s86;
	logic [2:0][52:0]   tc_s87;
	logic [100:0]       tnum_s88, tnum_s89, tnum_s90, tnum_s91;
	logic [55:0]        p_s89, p_s90, p_s91;
	logic               psat_s89;
	logic               sat_s90, sat_s91;
	logic               sinv_s90, sinv_s91;
	logic [55:0]        sph_s90, spl_s90;
	logic [100:0]       nums_s91;

	logic [101:0]       ksum_c;
	logic [86:0]        er_c;
	logic signed [28:0] gch_c [3];
	logic signed [28:0] ech_c [2];
	logic [127:0]       ta_c, tb_c;
	logic [74:0]        dm_c;
	logic [102:0]       tn_c;
	logic [79:0]        pr_c;
	logic [57:0]        s_c;
	logic [55:0]        smag_c;

	always_comb begin
		ksum_c = {2'd0, sq_s82[0]} + {2'd0, sq_s82[1]} + {2'd0, sq_s82[2]};
		er_c   = {{6{qs_s83[80]}}, qs_s83} - {2'd0, ke_s83};
		gch_c[0] = {6'd0, grho_s84[22:0]};
		gch_c[1] = {6'd0, grho_s84[45:23]};
		gch_c[2] = {{6{grho_s84[68]}}, grho_s84[68:46]};
		ech_c[0] = {1'b0, e_s84[27:0]};
		ech_c[1] = {e_s84[55], e_s84[55:28]};
		ta_c = '0;
		tb_c = '0;
		for (int i = 0; i < 3; i++) begin
			tb_c = tb_c + ({{70{pt_s85[i][0][57]}}, pt_s85[i][0]} << (23 * i));
			ta_c = ta_c + ({{70{pt_s85[i][1][57]}}, pt_s85[i][1]} << (23 * i + 28));
		end
		dm_c   = {2'd0, ddmag_s86};
		tn_c   = {tc_s87[2], 50'd0} + {25'd0, tc_s87[1], 25'd0} + {50'd0, tc_s87[0]};
		pr_c   = v_acc_s88[127:48];
		s_c    = {{2{p_s89[55]}}, p_s89} + {10'd0, stiffness_pressure_q};
		smag_c = s_c[57] ? 56'd0 : s_c[55:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s81 <= 1'b0; v_s82 <= 1'b0; v_s83 <= 1'b0; v_s84 <= 1'b0;
			v_s85 <= 1'b0; v_s86 <= 1'b0; v_s87 <= 1'b0; v_s88 <= 1'b0;
			v_s89 <= 1'b0; v_s90 <= 1'b0; v_s91 <= 1'b0;
		end else if (adv) begin
			v_s81 <= da_vld_s[NA-1];
			v_s82 <= v_s81; v_s83 <= v_s82; v_s84 <= v_s83; v_s85 <= v_s84;
			v_s86 <= v_s85; v_s87 <= v_s86; v_s88 <= v_s87; v_s89 <= v_s88;
			v_s90 <= v_s89; v_s91 <= v_s90;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 3; j++) begin
				hh_s81[j] <= u_c[j][49:25] * u_c[j][49:25];
				hl_s81[j] <= u_c[j][49:25] * u_c[j][24:0];
				ll_s81[j] <= u_c[j][24:0] * u_c[j][24:0];
			end
			qs_s81  <= qs_c;
			pr_s81  <= da_s[NA-1].rq[4][71:0];
			rho_s81 <= da_s[NA-1].rho;
			gph_s81 <= gm * $signed({1'b0, da_s[NA-1].rho[39:20]});
			gpl_s81 <= gm * $signed({1'b0, da_s[NA-1].rho[19:0]});

			for (int j = 0; j < 3; j++) begin
				sq_s82[j] <= {hh_s81[j], 50'd0} + {24'd0, hl_s81[j], 26'd0}
					+ {50'd0, ll_s81[j]};
			end
			grho_s82 <= {gph_s81[48:0], 20'd0} + {{19{gpl_s81[49]}}, gpl_s81};
			qs_s82   <= qs_s81;
			pr_s82   <= pr_s81;
			rho_s82  <= rho_s81;

			ke_s83   <= ksum_c[101:17];
			grho_s83 <= grho_s82;
			qs_s83   <= qs_s82;
			pr_s83   <= pr_s82;
			rho_s83  <= rho_s82;

			if ((&er_c[86:55]) || !(|er_c[86:55])) begin
				e_s84    <= er_c[55:0];
				esat_s84 <= 1'b0;
			end else begin
				e_s84    <= er_c[86] ? {1'b1, 55'd0} : {1'b0, {55{1'b1}}};
				esat_s84 <= 1'b1;
			end
			grho_s84 <= grho_s83;
			pr_s84   <= pr_s83;
			rho_s84  <= rho_s83;

			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 2; j++) begin
					pt_s85[i][j] <= gch_c[i] * ech_c[j];
				end
			end
			dd_s85   <= {{18{e_s84[55]}}, e_s84} - {2'd0, pr_s84};
			e_s85    <= e_s84;
			esat_s85 <= esat_s84;
			rho_s85  <= rho_s84;

			ta_s86    <= ta_c;
			tb_s86    <= tb_c;
			ddneg_s86 <= dd_s85[73];
			ddmag_s86 <= dd_s85[73] ? 73'(~dd_s85 + 74'd1) : dd_s85[72:0];
			e_s86     <= e_s85;
			esat_s86  <= esat_s85;
			rho_s86   <= rho_s85;

			t1_s87 <= ta_s86 + tb_s86;
			for (int i = 0; i < 3; i++) begin
				tc_s87[i] <= dm_c[25*i +: 25] * heat_ratio_q;
			end
			ddneg_s87 <= ddneg_s86;
			e_s87     <= e_s86;
			esat_s87  <= esat_s86;
			rho_s87   <= rho_s86;

			v_acc_s88 <= t1_s87 - {28'd0, gp0_q, 24'd0};
			tnum_s88  <= tn_c[100:0];
			ddneg_s88 <= ddneg_s87;
			e_s88     <= e_s87;
			esat_s88  <= esat_s87;
			rho_s88   <= rho_s87;

			if ((&pr_c[79:55]) || !(|pr_c[79:55])) begin
				p_s89    <= pr_c[55:0];
				psat_s89 <= 1'b0;
			end else begin
				p_s89    <= pr_c[79] ? {1'b1, 55'd0} : {1'b0, {55{1'b1}}};
				psat_s89 <= 1'b1;
			end
			tnum_s89  <= tnum_s88;
			ddneg_s89 <= ddneg_s88;
			e_s89     <= e_s88;
			esat_s89  <= esat_s88;
			rho_s89   <= rho_s88;

			sinv_s90  <= s_c[57];
			sph_s90   <= smag_c[55:28] * heat_ratio_q;
			spl_s90   <= smag_c[27:0] * heat_ratio_q;
			p_s90     <= p_s89;
			sat_s90   <= esat_s89 || psat_s89;
			tnum_s90  <= tnum_s89;
			ddneg_s90 <= ddneg_s89;
			e_s90     <= e_s89;
			rho_s90   <= rho_s89;

			nums_s91  <= {1'b0, ({sph_s90, 28'd0} + {28'd0, spl_s90}), 16'd0};
			sinv_s91  <= sinv_s90;
			p_s91     <= p_s90;
			sat_s91   <= sat_s90;
			tnum_s91  <= tnum_s90;
			ddneg_s91 <= ddneg_s90;
			e_s91     <= e_s90;
			rho_s91   <= rho_s90;
		end
	end

	// ---------------- sound and temperature division ----------------
	sgeos_pkg::divb_t db_s [NB];
	logic [NB-1:0]    db_vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			db_vld_s <= '0;
		end else if (adv) begin
			db_vld_s <= {db_vld_s[NB-2:0], v_s91};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			db_s[0].rho  <= rho_s91;
			db_s[0].sinv <= sinv_s91;
			db_s[0].tneg <= ddneg_s91;
			db_s[0].sat  <= sat_s91;
			db_s[0].e    <= e_s91;
			db_s[0].p    <= p_s91;
			db_s[0].rs   <= sgeos_pkg::div_step_s({41'd0, nums_s91}, rho_s91);
			db_s[0].rt   <= sgeos_pkg::div_step_t({49'd0, tnum_s91}, cp_div);
			for (int k = 1; k < NB; k++) begin
				db_s[k].rho  <= db_s[k-1].rho;
				db_s[k].sinv <= db_s[k-1].sinv;
				db_s[k].tneg <= db_s[k-1].tneg;
				db_s[k].sat  <= db_s[k-1].sat;
				db_s[k].e    <= db_s[k-1].e;
				db_s[k].p    <= db_s[k-1].p;
				db_s[k].rs   <= sgeos_pkg::div_step_s(db_s[k-1].rs, db_s[k-1].rho);
				db_s[k].rt   <= sgeos_pkg::div_step_t(db_s[k-1].rt, cp_div);
			end
		end
	end

	// ---------------- temperature clamp, square root ----------------
	logic [101:0]     tv_c;
	logic             tsat_c;
	logic             v_s193;
	sgeos_pkg::sqrt_t r_s193;
	sgeos_pkg::sqrt_t sq_s [NS];
	logic [NS-1:0]    sq_vld_s;

	always_comb begin
		tv_c = db_s[NB-1].tneg ? (~{1'b0, db_s[NB-1].rt[100:0]} + 102'd1)
			: {1'b0, db_s[NB-1].rt[100:0]};
		tsat_c = !((&tv_c[101:39]) || !(|tv_c[101:39]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s193   <= 1'b0;
			sq_vld_s <= '0;
		end else if (adv) begin
			v_s193   <= db_vld_s[NB-1];
			sq_vld_s <= {sq_vld_s[NS-2:0], v_s193};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s193.asat <= |db_s[NB-1].rs[100:80];
			r_s193.sinv <= db_s[NB-1].sinv;
			r_s193.sat  <= db_s[NB-1].sat || tsat_c;
			r_s193.e    <= db_s[NB-1].e;
			r_s193.p    <= db_s[NB-1].p;
			r_s193.t    <= tsat_c ? (tv_c[101] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}})
				: tv_c[39:0];
			r_s193.rem  <= '0;
			r_s193.root <= '0;
			r_s193.rad  <= db_s[NB-1].rs[79:0];
			sq_s[0] <= sgeos_pkg::sqrt_step(r_s193);
			for (int k = 1; k < NS; k++) begin
				sq_s[k] <= sgeos_pkg::sqrt_step(sq_s[k-1]);
			end
		end
	end

	// ---------------- output word ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= sq_vld_s[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			internal_energy <= sq_s[NS-1].e;
			pressure        <= sq_s[NS-1].p;
			sound_speed     <= sq_s[NS-1].asat ? {40{1'b1}} : sq_s[NS-1].root;
			temperature     <= sq_s[NS-1].t;
			sound_invalid   <= sq_s[NS-1].sinv;
			saturated       <= sq_s[NS-1].sat || sq_s[NS-1].asat;
		end
	end

`ifndef SYNTHESIS
	a_inv_zero_speed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sound_invalid |-> sound_speed == '0)
		else $error("sound speed nonzero on invalid argument");

	a_inv_neg_pressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sound_invalid |-> pressure[55])
		else $error("invalid sound argument with nonnegative pressure");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> $stable(da_vld_s) && $stable(db_vld_s) && $stable(sq_vld_s))
		else $error("pipeline moved during stall");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");
`endif

endmodule
